// File: sv/csce_pkg.sv
// Shared types, codes and helpers of the CIGAR soft clip editor.
package csce_pkg;

	localparam int MAX_ENTRIES_DEF = 64;
	localparam int RESULT_CAP      = 64;
	localparam int LEN_W           = 28;
	localparam int SUM_W           = 34;
	localparam int CODE_W          = 4;
	localparam int ENTRY_W         = CODE_W + LEN_W;

	typedef logic [CODE_W-1:0] code_t;

	localparam code_t C_M  = 4'd0;
	localparam code_t C_I  = 4'd1;
	localparam code_t C_D  = 4'd2;
	localparam code_t C_N  = 4'd3;
	localparam code_t C_S  = 4'd4;
	localparam code_t C_H  = 4'd5;
	localparam code_t C_P  = 4'd6;
	localparam code_t C_EQ = 4'd7;
	localparam code_t C_X  = 4'd8;

	// raw operation selectors on the input port
	localparam logic [2:0] SEL_APPEND = 3'd0;
	localparam logic [2:0] SEL_CLIP_R = 3'd1;
	localparam logic [2:0] SEL_CLIP_L = 3'd2;
	localparam logic [2:0] SEL_TRIM   = 3'd3;
	localparam logic [2:0] SEL_CLEAR  = 3'd4;
	localparam logic [2:0] SEL_DUMP   = 3'd5;

	typedef enum logic [2:0] {
		ST_OK,
		ST_AFTER_CLIP,
		ST_BAD_OP,
		ST_TOO_LONG,
		ST_UNSUP,
		ST_FULL
	} status_t;

	typedef enum logic [2:0] {
		OP_APPEND,
		OP_CLIP_R,
		OP_CLIP_L,
		OP_TRIM,
		OP_CLEAR,
		OP_DUMP,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t              op;
		code_t            code;
		logic             code_ok;
		logic [LEN_W-1:0] len;
	} cmd_t;

	// returns {valid, code}
	function automatic logic [CODE_W:0] char_code(input logic [7:0] ch);
		logic [CODE_W:0] r;
		case (ch)
			8'h4D:   r = {1'b1, C_M};
			8'h49:   r = {1'b1, C_I};
			8'h44:   r = {1'b1, C_D};
			8'h4E:   r = {1'b1, C_N};
			8'h53:   r = {1'b1, C_S};
			8'h48:   r = {1'b1, C_H};
			8'h50:   r = {1'b1, C_P};
			8'h3D:   r = {1'b1, C_EQ};
			8'h58:   r = {1'b1, C_X};
			default: r = {1'b0, C_M};
		endcase
		return r;
	endfunction

endpackage

// File: sv/cigar_soft_clip_editor_top.sv
// Top level of the CIGAR soft clip editor: front end, command queue and back end.
//
// The editor keeps one CIGAR as up to MAX_ENTRIES type/length entries in a
// single-port-read entry memory, plus running aligned, inserted, deleted and
// skipped totals and the left and right soft clip lengths. Every input item
// yields one result, except a dump, which yields one result per stored entry
// (at most 64, or one all-zero entry result on an empty stack); is_last marks
// the final result of an item. Items pass a registered decode stage and a
// two-entry queue, so the input side keeps taking items while the back end
// works or a result waits on out_ready. In the back end, a trim reads the
// first and last entries before it caps or drops their soft clips; a dump
// reads and presents the stored entries in turn; a clip walks entries from the
// clipped end, one memory read each, then writes any split entry and the new
// soft clip, or one merged soft clip when only the far soft clip remains; a
// zero-length or too-long clip skips the walk. The entry memory has one read
// port with registered read data. The memory needs no clearing pass after
// reset: only entries below the current count are ever used.
module cigar_soft_clip_editor_top #(
	parameter int MAX_ENTRIES = csce_pkg::MAX_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  operation,
	input  logic [7:0]                  op_char,
	input  logic [csce_pkg::LEN_W-1:0]  length,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  status,
	output logic [csce_pkg::CODE_W-1:0] entry_code,
	output logic [csce_pkg::LEN_W-1:0]  entry_length,
	output logic                        is_last,
	output logic [csce_pkg::SUM_W-1:0]  aligned_total,
	output logic [csce_pkg::SUM_W-1:0]  inserted_total,
	output logic [csce_pkg::SUM_W-1:0]  deleted_total,
	output logic [csce_pkg::SUM_W-1:0]  skipped_total,
	output logic [csce_pkg::LEN_W-1:0]  clip_left_len,
	output logic [csce_pkg::LEN_W-1:0]  clip_right_len
);
	import csce_pkg::*;

	// decoded command, front end to queue
	logic front_valid;
	logic front_ready;
	cmd_t front_cmd;

	// queue head, queue to back end
	logic back_valid;
	logic back_ready;
	cmd_t back_cmd;

	// Decode operation and operator on each input transfer.
	csce_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.op_char   (op_char),
		.length    (length),
		.cmd_valid (front_valid),
		.cmd       (front_cmd),
		.cmd_ready (front_ready)
	);

	// Hold decoded commands while the back end is busy.
	csce_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.wr_cmd   (front_cmd),
		.rd_valid (back_valid),
		.rd_ready (back_ready),
		.rd_cmd   (back_cmd)
	);

	// Execute commands against the entry memory and present results.
	csce_back #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (back_valid),
		.cmd            (back_cmd),
		.cmd_ready      (back_ready),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.entry_code     (entry_code),
		.entry_length   (entry_length),
		.is_last        (is_last),
		.aligned_total  (aligned_total),
		.inserted_total (inserted_total),
		.deleted_total  (deleted_total),
		.skipped_total  (skipped_total),
		.clip_left_len  (clip_left_len),
		.clip_right_len (clip_right_len)
	);

endmodule

// File: sv/csce_front.sv
// Front end: accepts input items, decodes operation and operator, registers the command.
module csce_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [2:0]                 operation,
	input  logic [7:0]                 op_char,
	input  logic [csce_pkg::LEN_W-1:0] length,
	output logic                       cmd_valid,
	output csce_pkg::cmd_t             cmd,
	input  logic                       cmd_ready
);
	import csce_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t dec;

	always_comb begin
		case (operation)
			SEL_APPEND: dec.op = OP_APPEND;
			SEL_CLIP_R: dec.op = OP_CLIP_R;
			SEL_CLIP_L: dec.op = OP_CLIP_L;
			SEL_TRIM:   dec.op = OP_TRIM;
			SEL_CLEAR:  dec.op = OP_CLEAR;
			SEL_DUMP:   dec.op = OP_DUMP;
			default:    dec.op = OP_NOP;
		endcase
		{dec.code_ok, dec.code} = char_code(op_char);
		dec.len = length;
	end

	assign in_ready  = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1 <= dec;
		end
	end

endmodule

// File: sv/csce_queue.sv
// Two-entry command queue between front end and back end.
module csce_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  csce_pkg::cmd_t wr_cmd,
	output logic           rd_valid,
	input  logic           rd_ready,
	output csce_pkg::cmd_t rd_cmd
);
	import csce_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;

	assign wr_ready = (fill_q != 2'd2);
	assign rd_valid = (fill_q != 2'd0);
	assign rd_cmd   = slot_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) fill_q <= fill_q + 2'd1;
			else if (pop && !push) fill_q <= fill_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= wr_cmd;
	end

endmodule

// File: sv/csce_back.sv
// Back end: entry memory, running totals, clip/trim/dump sequencer and result register.
module csce_back #(
	parameter int MAX_ENTRIES = csce_pkg::MAX_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	input  csce_pkg::cmd_t             cmd,
	output logic                       cmd_ready,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [2:0]                 status,
	output logic [csce_pkg::CODE_W-1:0] entry_code,
	output logic [csce_pkg::LEN_W-1:0] entry_length,
	output logic                       is_last,
	output logic [csce_pkg::SUM_W-1:0] aligned_total,
	output logic [csce_pkg::SUM_W-1:0] inserted_total,
	output logic [csce_pkg::SUM_W-1:0] deleted_total,
	output logic [csce_pkg::SUM_W-1:0] skipped_total,
	output logic [csce_pkg::LEN_W-1:0] clip_left_len,
	output logic [csce_pkg::LEN_W-1:0] clip_right_len
);
	import csce_pkg::*;

	localparam int AW       = $clog2(MAX_ENTRIES);
	localparam int CW       = $clog2(MAX_ENTRIES + 1);
	localparam int DUMP_MAX = (MAX_ENTRIES < RESULT_CAP) ? MAX_ENTRIES : RESULT_CAP;
	localparam logic [CW-1:0] MAX_C  = CW'(MAX_ENTRIES);
	localparam logic [CW-1:0] DUMP_C = CW'(DUMP_MAX);
	localparam logic [CW-1:0] ONE_C  = CW'(1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_OUT,
		S_CFARW,
		S_CRD,
		S_CPROC,
		S_CEND,
		S_CW1,
		S_CW2,
		S_TFW,
		S_TB,
		S_TW2,
		S_DRD,
		S_DWT
	} state_t;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] b, input logic [CW-1:0] l);
		logic [CW:0] s;
		s = (CW+1)'(b) + (CW+1)'(l);
		if (s >= (CW+1)'(MAX_ENTRIES)) s = s - (CW+1)'(MAX_ENTRIES);
		return s[AW-1:0];
	endfunction

	function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
	                                             input logic [LEN_W-1:0] b);
		logic [LEN_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[LEN_W] ? {LEN_W{1'b1}} : s[LEN_W-1:0];
	endfunction

	// memory
	logic [ENTRY_W-1:0] mem_q [MAX_ENTRIES];
	logic [ENTRY_W-1:0] rdata_q;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [ENTRY_W-1:0] wr_data;

	// state
	state_t           state_q;
	logic [AW-1:0]    base_q;
	logic [CW-1:0]    count_q;
	logic [SUM_W-1:0] sum_aln_q, sum_ins_q, sum_del_q, sum_skp_q;
	logic [LEN_W-1:0] lclip_q, rclip_q;
	logic             hp_q;

	// work registers
	status_t          status_q;
	logic [LEN_W-1:0] len_q;
	logic             left_q;
	logic [ENTRY_W-1:0] far_q;
	logic [ENTRY_W-1:0] back_q;
	logic [CW-1:0]    n_rem_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] acc_q;
	logic             first_q;
	logic             part_q;
	code_t            part_code_q;
	logic [LEN_W-1:0] part_len_q;
	logic [SUM_W-1:0] d_aln_q, d_ins_q, d_del_q, d_skp_q;
	logic [CW-1:0]    idx_q;

	// result register
	logic             out_valid_q;
	status_t          res_status_q;
	code_t            res_code_q;
	logic [LEN_W-1:0] res_len_q;
	logic             res_last_q;
	logic [SUM_W-1:0] res_aln_q, res_ins_q, res_del_q, res_skp_q;
	logic [LEN_W-1:0] res_lclip_q, res_rclip_q;

	// helpers
	code_t            e_code;
	logic [LEN_W-1:0] e_len;
	logic [LEN_W-1:0] take;
	logic [CW-1:0]    near_idx;
	logic [CW-1:0]    k_off;
	logic [AW-1:0]    far_phys;
	logic [AW-1:0]    s_phys;
	logic             merge;
	logic [LEN_W-1:0] merged_len;
	logic [LEN_W-1:0] near_clip;
	logic [LEN_W-1:0] far_clip;
	logic             app_ok;
	logic             out_free;
	logic [CW-1:0]    dump_n;
	logic             front_s;
	logic             back_s;

	assign e_code     = rdata_q[ENTRY_W-1:LEN_W];
	assign e_len      = rdata_q[LEN_W-1:0];
	assign take       = (rem_q >= e_len) ? e_len : rem_q;
	assign k_off      = count_q - n_rem_q;
	assign near_idx   = left_q ? k_off : (n_rem_q - ONE_C);
	assign far_phys   = left_q ? phys(base_q, count_q - ONE_C) : base_q;
	assign merge      = (n_rem_q == ONE_C) && (far_q[ENTRY_W-1:LEN_W] == C_S);
	assign merged_len = sat_add(far_q[LEN_W-1:0], acc_q);
	assign near_clip  = (n_rem_q != '0) ? acc_q : '0;
	assign far_clip   = (n_rem_q == '0) ? acc_q :
	                    ((far_q[ENTRY_W-1:LEN_W] == C_S) ? far_q[LEN_W-1:0] : '0);
	assign app_ok     = (rclip_q == '0) && cmd.code_ok && (count_q < MAX_C);
	assign out_free   = !out_valid_q || out_ready;
	assign dump_n     = (count_q > DUMP_C) ? DUMP_C : count_q;
	assign front_s    = (far_q[ENTRY_W-1:LEN_W] == C_S);
	assign back_s     = (back_q[ENTRY_W-1:LEN_W] == C_S);
	assign cmd_ready  = (state_q == S_IDLE);

	always_comb begin
		if (!left_q) begin
			s_phys = phys(base_q, n_rem_q);
		end else if (k_off == '0) begin
			s_phys = (base_q == '0) ? AW'(MAX_ENTRIES - 1) : (base_q - AW'(1));
		end else begin
			s_phys = phys(base_q, k_off - ONE_C);
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = phys(base_q, near_idx);
		wr_en   = 1'b0;
		wr_addr = phys(base_q, count_q);
		wr_data = {cmd.code, cmd.len};
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						OP_APPEND: wr_en = app_ok;
						OP_CLIP_R: begin
							rd_en   = 1'b1;
							rd_addr = base_q;
						end
						OP_CLIP_L: begin
							rd_en   = 1'b1;
							rd_addr = phys(base_q, count_q - ONE_C);
						end
						OP_TRIM: begin
							rd_en   = 1'b1;
							rd_addr = base_q;
						end
						default: ;
					endcase
				end
			end
			S_CRD: rd_en = 1'b1;
			S_TFW: begin
				rd_en   = 1'b1;
				rd_addr = phys(base_q, count_q - ONE_C);
			end
			S_TB: begin
				wr_en   = (len_q != '0) && front_s && (far_q[LEN_W-1:0] > len_q);
				wr_addr = base_q;
				wr_data = {C_S, len_q};
			end
			S_TW2: begin
				wr_en   = back_s && (back_q[LEN_W-1:0] > len_q);
				wr_addr = phys(base_q, count_q - ONE_C);
				wr_data = {C_S, len_q};
			end
			S_CW1: begin
				if (merge) begin
					wr_en   = 1'b1;
					wr_addr = far_phys;
					wr_data = {C_S, merged_len};
				end else begin
					wr_en   = part_q;
					wr_addr = phys(base_q, near_idx);
					wr_data = {part_code_q, part_len_q};
				end
			end
			S_CW2: begin
				wr_en   = 1'b1;
				wr_addr = s_phys;
				wr_data = {C_S, acc_q};
			end
			S_DRD: begin
				rd_en   = 1'b1;
				rd_addr = phys(base_q, idx_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			base_q       <= '0;
			count_q      <= '0;
			sum_aln_q    <= '0;
			sum_ins_q    <= '0;
			sum_del_q    <= '0;
			sum_skp_q    <= '0;
			lclip_q      <= '0;
			rclip_q      <= '0;
			hp_q         <= 1'b0;
			status_q     <= ST_OK;
			len_q        <= '0;
			left_q       <= 1'b0;
			far_q        <= '0;
			back_q       <= '0;
			n_rem_q      <= '0;
			rem_q        <= '0;
			acc_q        <= '0;
			first_q      <= 1'b0;
			part_q       <= 1'b0;
			part_code_q  <= C_M;
			part_len_q   <= '0;
			d_aln_q      <= '0;
			d_ins_q      <= '0;
			d_del_q      <= '0;
			d_skp_q      <= '0;
			idx_q        <= '0;
			out_valid_q  <= 1'b0;
			res_status_q <= ST_OK;
			res_code_q   <= C_M;
			res_len_q    <= '0;
			res_last_q   <= 1'b0;
			res_aln_q    <= '0;
			res_ins_q    <= '0;
			res_del_q    <= '0;
			res_skp_q    <= '0;
			res_lclip_q  <= '0;
			res_rclip_q  <= '0;
		end else begin
			if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						len_q    <= cmd.len;
						left_q   <= (cmd.op == OP_CLIP_L);
						status_q <= ST_OK;
						state_q  <= S_OUT;
						case (cmd.op)
							OP_APPEND: begin
								if (rclip_q != '0) begin
									status_q <= ST_AFTER_CLIP;
								end else if (!cmd.code_ok) begin
									status_q <= ST_BAD_OP;
								end else if (count_q >= MAX_C) begin
									status_q <= ST_FULL;
								end else begin
									count_q <= count_q + ONE_C;
									if (cmd.code inside {C_M, C_EQ, C_X})
										sum_aln_q <= sum_aln_q + SUM_W'(cmd.len);
									else if (cmd.code == C_I)
										sum_ins_q <= sum_ins_q + SUM_W'(cmd.len);
									else if (cmd.code == C_D)
										sum_del_q <= sum_del_q + SUM_W'(cmd.len);
									else if (cmd.code == C_N)
										sum_skp_q <= sum_skp_q + SUM_W'(cmd.len);
									else if (cmd.code == C_S) begin
										if (count_q == '0) lclip_q <= cmd.len;
										else rclip_q <= cmd.len;
									end else if (cmd.code inside {C_H, C_P})
										hp_q <= 1'b1;
								end
							end
							OP_CLIP_R, OP_CLIP_L: begin
								if (cmd.len == '0) begin
									if (cmd.op == OP_CLIP_L) begin
										lclip_q <= rclip_q;
										rclip_q <= lclip_q;
									end
								end else if ({7'd0, cmd.len} >
								             ({1'b0, sum_aln_q} + {1'b0, sum_ins_q})) begin
									status_q <= ST_TOO_LONG;
								end else begin
									n_rem_q <= count_q;
									rem_q   <= cmd.len;
									acc_q   <= '0;
									first_q <= 1'b1;
									part_q  <= 1'b0;
									d_aln_q <= '0;
									d_ins_q <= '0;
									d_del_q <= '0;
									d_skp_q <= '0;
									state_q <= S_CFARW;
								end
							end
							OP_TRIM: begin
								if (count_q != '0) state_q <= S_TFW;
							end
							OP_CLEAR: begin
								base_q    <= '0;
								count_q   <= '0;
								sum_aln_q <= '0;
								sum_ins_q <= '0;
								sum_del_q <= '0;
								sum_skp_q <= '0;
								lclip_q   <= '0;
								rclip_q   <= '0;
								hp_q      <= 1'b0;
							end
							OP_DUMP: begin
								idx_q <= '0;
								if (count_q != '0) state_q <= S_DRD;
							end
							default: ;
						endcase
					end
				end
				S_CFARW: begin
					far_q   <= rdata_q;
					state_q <= S_CRD;
				end
				S_CRD: begin
					if ((n_rem_q == '0) || (!first_q && (rem_q == '0))) state_q <= S_CEND;
					else state_q <= S_CPROC;
				end
				S_CPROC: begin
					first_q <= 1'b0;
					state_q <= S_CRD;
					if (first_q && (e_code == C_S)) begin
						acc_q   <= sat_add(acc_q, e_len);
						n_rem_q <= n_rem_q - ONE_C;
					end else if (e_code == C_I) begin
						acc_q   <= sat_add(acc_q, e_len);
						d_ins_q <= d_ins_q + SUM_W'(e_len);
						n_rem_q <= n_rem_q - ONE_C;
					end else if (e_code inside {C_D, C_N, C_M, C_EQ, C_X}) begin
						if (e_code == C_D) d_del_q <= d_del_q + SUM_W'(take);
						else if (e_code == C_N) d_skp_q <= d_skp_q + SUM_W'(take);
						else begin
							acc_q   <= sat_add(acc_q, take);
							d_aln_q <= d_aln_q + SUM_W'(take);
						end
						rem_q <= rem_q - take;
						if (take == e_len) begin
							n_rem_q <= n_rem_q - ONE_C;
						end else begin
							part_q      <= 1'b1;
							part_code_q <= e_code;
							part_len_q  <= e_len - take;
						end
					end else begin
						status_q <= ST_UNSUP;
						state_q  <= S_OUT;
					end
				end
				S_CEND: begin
					state_q <= S_OUT;
					if (rem_q != '0) begin
						status_q <= ST_TOO_LONG;
					end else if (n_rem_q >= MAX_C) begin
						status_q <= ST_FULL;
					end else if (hp_q) begin
						status_q <= ST_UNSUP;
					end else begin
						sum_aln_q <= sum_aln_q - d_aln_q;
						sum_ins_q <= sum_ins_q - d_ins_q;
						sum_del_q <= sum_del_q - d_del_q;
						sum_skp_q <= sum_skp_q - d_skp_q;
						state_q   <= S_CW1;
					end
				end
				S_CW1: begin
					if (merge) begin
						count_q <= ONE_C;
						base_q  <= far_phys;
						lclip_q <= left_q ? '0 : merged_len;
						rclip_q <= left_q ? merged_len : '0;
						state_q <= S_OUT;
					end else begin
						state_q <= S_CW2;
					end
				end
				S_CW2: begin
					count_q <= n_rem_q + ONE_C;
					if (left_q) base_q <= s_phys;
					lclip_q <= left_q ? near_clip : far_clip;
					rclip_q <= left_q ? far_clip : near_clip;
					state_q <= S_OUT;
				end
				S_TFW: begin
					far_q   <= rdata_q;
					state_q <= S_TB;
				end
				S_TB: begin
					back_q <= rdata_q;
					if (len_q == '0) begin
						lclip_q <= '0;
						rclip_q <= '0;
						state_q <= S_OUT;
						if (front_s) begin
							base_q <= phys(base_q, ONE_C);
							if (count_q == ONE_C) count_q <= '0;
							else if (e_code == C_S) count_q <= count_q - CW'(2);
							else count_q <= count_q - ONE_C;
						end else if (e_code == C_S) begin
							count_q <= count_q - ONE_C;
						end
					end else begin
						if (front_s && (far_q[LEN_W-1:0] > len_q)) lclip_q <= len_q;
						state_q <= S_TW2;
					end
				end
				S_TW2: begin
					if (back_s && (back_q[LEN_W-1:0] > len_q))
						rclip_q <= len_q;
					state_q <= S_OUT;
				end
				S_DRD: begin
					state_q <= S_DWT;
				end
				S_DWT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						res_status_q <= ST_OK;
						res_code_q   <= e_code;
						res_len_q    <= e_len;
						res_last_q   <= ((idx_q + ONE_C) == dump_n);
						res_aln_q    <= sum_aln_q;
						res_ins_q    <= sum_ins_q;
						res_del_q    <= sum_del_q;
						res_skp_q    <= sum_skp_q;
						res_lclip_q  <= lclip_q;
						res_rclip_q  <= rclip_q;
						if ((idx_q + ONE_C) == dump_n) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + ONE_C;
							state_q <= S_DRD;
						end
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						res_status_q <= status_q;
						res_code_q   <= C_M;
						res_len_q    <= '0;
						res_last_q   <= 1'b1;
						res_aln_q    <= sum_aln_q;
						res_ins_q    <= sum_ins_q;
						res_del_q    <= sum_del_q;
						res_skp_q    <= sum_skp_q;
						res_lclip_q  <= lclip_q;
						res_rclip_q  <= rclip_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = res_status_q;
	assign entry_code     = res_code_q;
	assign entry_length   = res_len_q;
	assign is_last        = res_last_q;
	assign aligned_total  = res_aln_q;
	assign inserted_total = res_ins_q;
	assign deleted_total  = res_del_q;
	assign skipped_total  = res_skp_q;
	assign clip_left_len  = res_lclip_q;
	assign clip_right_len = res_rclip_q;

endmodule

// File: sv/csce_checker.sv
// Port-level checker of the CIGAR soft clip editor, bound to the top level.
module csce_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [2:0]                  status,
	input logic [csce_pkg::CODE_W-1:0] entry_code,
	input logic [csce_pkg::LEN_W-1:0]  entry_length,
	input logic                        is_last,
	input logic [csce_pkg::LEN_W-1:0]  clip_right_len
);
	import csce_pkg::*;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// an error result is a single result with no entry payload
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |->
			is_last && (entry_code == C_M) && (entry_length == '0))
		else $error("error result carries entry data or is not last");

	// a refused append reports a right clip that is still present
	a_after_clip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_AFTER_CLIP) |-> (clip_right_len != '0))
		else $error("append refused without a right soft clip");

	// dumped codes are always known entry types
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (entry_code <= C_X))
		else $error("unknown entry code on output");

endmodule

bind cigar_soft_clip_editor_top csce_checker u_csce_checker (.*);

// File: tb/tb_cigar_soft_clip_editor_top.sv
// Self-checking testbench for the CIGAR soft clip editor top level.
module tb_cigar_soft_clip_editor_top;
	timeunit 1ns;
	timeprecision 1ps;
	import csce_pkg::*;

	// Selectors with no operation behind them; the block treats them as no-ops.
	localparam logic [2:0] SEL_SPARE6 = 3'd6;
	localparam logic [2:0] SEL_SPARE7 = 3'd7;

	// ASCII CIGAR operators.
	localparam logic [7:0] CH_M   = 8'h4D;
	localparam logic [7:0] CH_I   = 8'h49;
	localparam logic [7:0] CH_D   = 8'h44;
	localparam logic [7:0] CH_N   = 8'h4E;
	localparam logic [7:0] CH_S   = 8'h53;
	localparam logic [7:0] CH_H   = 8'h48;
	localparam logic [7:0] CH_P   = 8'h50;
	localparam logic [7:0] CH_EQ  = 8'h3D;
	localparam logic [7:0] CH_X   = 8'h58;
	localparam logic [7:0] CH_BAD = 8'h51;

	localparam int          DEPTH   = 64;
	localparam logic [27:0] LEN_MAX = 28'hFFFFFFF;

	typedef struct {
		logic [2:0]  op;
		logic [7:0]  ch;
		logic [27:0] len;
		bit          drain; // marker: hold the sender until all results are back
	} cmd_item_t;

	typedef struct {
		status_t     st;
		code_t       code;
		logic [27:0] elen;
		logic        last;
		logic [33:0] aln, ins, del, skp;
		logic [27:0] lcl, rcl;
	} cigar_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  operation = '0;
	logic [7:0]  op_char = '0;
	logic [27:0] length = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	code_t       entry_code;
	logic [27:0] entry_length;
	logic        is_last;
	logic [33:0] aligned_total, inserted_total, deleted_total, skipped_total;
	logic [27:0] clip_left_len, clip_right_len;

	cigar_soft_clip_editor_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .op_char(op_char), .length(length),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .entry_code(entry_code), .entry_length(entry_length),
		.is_last(is_last),
		.aligned_total(aligned_total), .inserted_total(inserted_total),
		.deleted_total(deleted_total), .skipped_total(skipped_total),
		.clip_left_len(clip_left_len), .clip_right_len(clip_right_len)
	);

	always #5 clk = ~clk;

	// Predicted state of the CIGAR editor.
	logic [31:0] cig_mem [DEPTH];
	logic [31:0] work_mem [DEPTH];
	int          cig_n;
	logic [33:0] tot_aln, tot_ins, tot_del, tot_skp;
	logic [27:0] lclip, rclip;

	cmd_item_t     cmd_q[$];
	cigar_result_t cigar_exp_q[$];
	int            mismatches = 0;
	int            items_sent = 0;
	int            results_seen = 0;
	int            dumps_seen = 0;
	int            status_hits [8];
	bit            no_idle = 1'b0;
	bit            stim_done = 1'b0;

	function automatic bit is_aln(code_t c);
		return c == C_M || c == C_EQ || c == C_X;
	endfunction

	// Build an entry; lengths past 28 bits saturate.
	function automatic logic [31:0] mk(code_t c, logic [63:0] l);
		if (l > 64'(LEN_MAX))
			l = 64'(LEN_MAX);
		return {c, l[27:0]};
	endfunction

	task automatic cig_clear();
		cig_n = 0;
		tot_aln = '0; tot_ins = '0; tot_del = '0; tot_skp = '0;
		lclip = '0; rclip = '0;
	endtask

	task automatic recount();
		code_t c;
		for (int i = 0; i < DEPTH; i++) begin
			if (i < cig_n) begin
				c = cig_mem[i][31:28];
				if (c == C_I) tot_ins += 34'(cig_mem[i][27:0]);
				else if (c == C_D) tot_del += 34'(cig_mem[i][27:0]);
				else if (c == C_N) tot_skp += 34'(cig_mem[i][27:0]);
				else if (is_aln(c)) tot_aln += 34'(cig_mem[i][27:0]);
			end
		end
	endtask

	task automatic reverse_work(int n);
		logic [31:0] t;
		for (int i = 0; i < n / 2; i++) begin
			t = work_mem[i];
			work_mem[i] = work_mem[n - 1 - i];
			work_mem[n - 1 - i] = t;
		end
	endtask

	// Clip len bases off the back end of the work copy.
	task automatic clip_work(inout int n, input logic [63:0] len, output status_t st);
		logic [63:0] acc, rem, take, l;
		code_t       c;
		acc = 0;
		rem = len;
		st = ST_OK;
		if (len > 64'(tot_aln) + 64'(tot_ins)) begin
			st = ST_TOO_LONG;
			return;
		end
		if (n > 0 && work_mem[n - 1][31:28] == C_S) begin
			acc += 64'(work_mem[n - 1][27:0]);
			n--;
		end
		while (rem > 0 && n > 0) begin
			c = work_mem[n - 1][31:28];
			l = 64'(work_mem[n - 1][27:0]);
			if (c == C_I) begin
				acc += l;
				n--;
			end else if (c == C_D || c == C_N || is_aln(c)) begin
				take = (rem >= l) ? l : rem;
				if (is_aln(c))
					acc += take;
				rem -= take;
				if (take == l)
					n--;
				else
					work_mem[n - 1] = mk(c, l - take);
			end else begin
				st = ST_UNSUP;
				return;
			end
		end
		if (rem > 0) begin
			st = ST_TOO_LONG;
			return;
		end
		if (n >= DEPTH) begin
			st = ST_FULL;
			return;
		end
		work_mem[n] = mk(C_S, acc);
		n++;
		// two lone soft clips merge into one
		if (n == 2 && work_mem[0][31:28] == C_S) begin
			work_mem[0] = mk(C_S, 64'(work_mem[0][27:0]) + 64'(work_mem[1][27:0]));
			n = 1;
		end
		for (int i = 0; i < n; i++)
			if (work_mem[i][31:28] == C_H || work_mem[i][31:28] == C_P)
				st = ST_UNSUP;
	endtask

	task automatic clip_cigar(logic [27:0] len, bit left, output status_t st);
		int          n;
		logic [27:0] t, fl, fr;
		n = cig_n;
		st = ST_OK;
		if (len == 0) begin
			if (left) begin
				t = lclip; lclip = rclip; rclip = t;
			end
			return;
		end
		work_mem = cig_mem;
		if (left)
			reverse_work(n);
		clip_work(n, 64'(len), st);
		if (st != ST_OK)
			return;
		if (left)
			reverse_work(n);
		cig_mem = work_mem;
		cig_clear();
		cig_n = n;
		recount();
		fl = '0;
		fr = '0;
		if (n > 0 && cig_mem[0][31:28] == C_S) fl = cig_mem[0][27:0];
		if (n > 1 && cig_mem[n - 1][31:28] == C_S) fr = cig_mem[n - 1][27:0];
		if (left) begin
			// counted in the reversed frame, then swapped
			lclip = (n > 1 && cig_mem[0][31:28] == C_S) ? cig_mem[0][27:0] : '0;
			rclip = (n > 0 && cig_mem[n - 1][31:28] == C_S) ? cig_mem[n - 1][27:0] : '0;
		end else begin
			lclip = fl;
			rclip = fr;
		end
	endtask

	task automatic append_entry(logic [7:0] ch, logic [27:0] len, output status_t st);
		code_t c;
		bit    known;
		known = 1'b1;
		case (ch)
			CH_M:    c = C_M;
			CH_I:    c = C_I;
			CH_D:    c = C_D;
			CH_N:    c = C_N;
			CH_S:    c = C_S;
			CH_H:    c = C_H;
			CH_P:    c = C_P;
			CH_EQ:   c = C_EQ;
			CH_X:    c = C_X;
			default: begin
				c = C_M;
				known = 1'b0;
			end
		endcase
		st = ST_OK;
		if (rclip != 0) st = ST_AFTER_CLIP;
		else if (!known) st = ST_BAD_OP;
		else if (cig_n >= DEPTH) st = ST_FULL;
		else begin
			if (is_aln(c)) tot_aln += 34'(len);
			else if (c == C_I) tot_ins += 34'(len);
			else if (c == C_D) tot_del += 34'(len);
			else if (c == C_N) tot_skp += 34'(len);
			else if (c == C_S) begin
				if (cig_n == 0) lclip = len;
				else rclip = len;
			end
			cig_mem[cig_n] = mk(c, 64'(len));
			cig_n++;
		end
	endtask

	task automatic trim_clips(logic [27:0] cap);
		if (cig_n == 0)
			return;
		if (cap == 0) begin
			if (cig_mem[0][31:28] == C_S) begin
				for (int i = 0; i < DEPTH - 1; i++)
					if (i < cig_n - 1)
						cig_mem[i] = cig_mem[i + 1];
				cig_n--;
			end
			if (cig_n > 0 && cig_mem[cig_n - 1][31:28] == C_S)
				cig_n--;
			lclip = '0;
			rclip = '0;
			return;
		end
		if (cig_mem[0][31:28] == C_S && cig_mem[0][27:0] > cap) begin
			cig_mem[0] = mk(C_S, 64'(cap));
			lclip = cap;
		end
		if (cig_mem[cig_n - 1][31:28] == C_S && cig_mem[cig_n - 1][27:0] > cap) begin
			cig_mem[cig_n - 1] = mk(C_S, 64'(cap));
			rclip = cap;
		end
	endtask

	task automatic push_result(status_t st, code_t c, logic [27:0] l, logic last);
		cigar_result_t r;
		r.st = st; r.code = c; r.elen = l; r.last = last;
		r.aln = tot_aln; r.ins = tot_ins; r.del = tot_del; r.skp = tot_skp;
		r.lcl = lclip; r.rcl = rclip;
		cigar_exp_q.insert(cigar_exp_q.size(), r);
	endtask

	// Apply one accepted command to the predicted state and queue its results.
	task automatic predict_cigar(logic [2:0] op, logic [7:0] ch, logic [27:0] len);
		status_t st;
		int      n;
		st = ST_OK;
		case (op)
			SEL_APPEND: append_entry(ch, len, st);
			SEL_CLIP_R: clip_cigar(len, 1'b0, st);
			SEL_CLIP_L: clip_cigar(len, 1'b1, st);
			SEL_TRIM:   trim_clips(len);
			SEL_CLEAR:  cig_clear();
			SEL_DUMP: begin
				n = (cig_n > RESULT_CAP) ? RESULT_CAP : cig_n;
				if (n == 0)
					push_result(ST_OK, C_M, '0, 1'b1);
				for (int i = 0; i < n; i++)
					push_result(ST_OK, cig_mem[i][31:28], cig_mem[i][27:0], i + 1 == n);
				return;
			end
			default: ;
		endcase
		push_result(st, C_M, '0, 1'b1);
	endtask

	task automatic report(string msg);
		$display("ERROR @%0t result %0d: %s", $realtime, results_seen, msg);
		mismatches++;
	endtask

	task automatic check_field(string f, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report($sformatf("%s got 0x%0h want 0x%0h", f, got, want));
	endtask

	// Idle length: mostly none or short, now and then long.
	function automatic int idle_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Sender: present queued commands, predict each one on its transfer.
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		logic nv;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			nv = in_valid;
			if (in_valid && in_ready) begin
				predict_cigar(operation, op_char, length);
				items_sent++;
				void'(cmd_q.pop_front());
				nv = 1'b0;
				send_gap = idle_gap();
			end
			if (!nv) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (cmd_q.size() > 0) begin
					if (cmd_q[0].drain) begin
						// release the pause only once every result is back
						if (cigar_exp_q.size() == 0)
							void'(cmd_q.pop_front());
					end else begin
						nv = 1'b1;
						operation <= cmd_q[0].op;
						op_char <= cmd_q[0].ch;
						length <= cmd_q[0].len;
					end
				end
			end
			in_valid <= nv;
		end
	end

	// Receiver: random back-pressure, one long hold-off, field-by-field check.
	int  recv_gap = 0;
	bit  long_hold_done = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		cigar_result_t w;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				status_hits[status]++;
				if (entry_length != 0) dumps_seen++;
				if (cigar_exp_q.size() == 0) begin
					report("result with nothing expected");
				end else begin
					w = cigar_exp_q.pop_front();
					check_field("status", 64'(status), 64'(w.st));
					check_field("entry_code", 64'(entry_code), 64'(w.code));
					check_field("entry_length", 64'(entry_length), 64'(w.elen));
					check_field("is_last", 64'(is_last), 64'(w.last));
					check_field("aligned_total", 64'(aligned_total), 64'(w.aln));
					check_field("inserted_total", 64'(inserted_total), 64'(w.ins));
					check_field("deleted_total", 64'(deleted_total), 64'(w.del));
					check_field("skipped_total", 64'(skipped_total), 64'(w.skp));
					check_field("clip_left_len", 64'(clip_left_len), 64'(w.lcl));
					check_field("clip_right_len", 64'(clip_right_len), 64'(w.rcl));
				end
				// starve the output for a long stretch once, so the input backs up
				if (!long_hold_done && results_seen == 60) begin
					long_hold_done = 1'b1;
					recv_gap = 400;
				end else begin
					recv_gap = idle_gap();
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic add(logic [2:0] op, logic [7:0] ch, logic [27:0] len);
		cmd_item_t it;
		it = '{op, ch, len, 1'b0};
		cmd_q.insert(cmd_q.size(), it);
	endtask

	task automatic add_drain();
		cmd_item_t it;
		it = '{SEL_CLEAR, 8'h00, 28'h0, 1'b1};
		cmd_q.insert(cmd_q.size(), it);
	endtask

	function automatic logic [27:0] rand_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 50);
		if (r < 85) return $urandom_range(0, 300);
		if (r < 95) return 28'($urandom());
		return LEN_MAX;
	endfunction

	function automatic logic [7:0] body_char();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0:       return CH_I;
			1:       return CH_D;
			2:       return CH_N;
			3:       return CH_EQ;
			4:       return CH_X;
			default: return CH_M;
		endcase
	endfunction

	// Well-formed read: optional soft clips around a body, then edits and a dump.
	task automatic add_read();
		int k;
		add(SEL_CLEAR, 8'($urandom()), 28'($urandom()));
		if ($urandom_range(0, 9) < 4) add(SEL_APPEND, CH_S, rand_len());
		add(SEL_APPEND, CH_M, rand_len());
		k = $urandom_range(0, 6);
		repeat (k) add(SEL_APPEND, body_char(), rand_len());
		if ($urandom_range(0, 19) == 0)
			add(SEL_APPEND, ($urandom_range(0, 1) != 0) ? CH_H : CH_P, rand_len());
		if ($urandom_range(0, 9) < 3) add(SEL_APPEND, CH_S, rand_len());
		k = $urandom_range(1, 3);
		repeat (k) begin
			case ($urandom_range(0, 5))
				0, 1:    add(SEL_CLIP_R, 8'($urandom()), ($urandom_range(0, 9) == 0) ?
						28'd0 : 28'($urandom_range(1, 60)));
				2, 3:    add(SEL_CLIP_L, 8'($urandom()), ($urandom_range(0, 9) == 0) ?
						28'd0 : 28'($urandom_range(1, 60)));
				4:       add(SEL_TRIM, 8'($urandom()), 28'($urandom_range(0, 30)));
				default: add(SEL_APPEND, body_char(), rand_len());
			endcase
		end
		add(SEL_DUMP, 8'($urandom()), 28'($urandom()));
	endtask

	initial begin
		int target;
		for (int i = 0; i < DEPTH; i++) begin
			cig_mem[i] = '0;
			work_mem[i] = '0;
		end
		cig_clear();

		// Directed: empty stack, every operator but P, clip and trim corner cases.
		add(SEL_CLEAR, 8'hFF, LEN_MAX);
		add(SEL_DUMP, 8'h00, 28'h0);
		add(SEL_TRIM, 8'h00, 28'd5);
		add(SEL_APPEND, CH_S, 28'd7);
		add(SEL_APPEND, CH_M, 28'd20);
		add(SEL_APPEND, CH_I, 28'd3);
		add(SEL_APPEND, CH_D, 28'd4);
		add(SEL_APPEND, CH_N, 28'd2);
		add(SEL_APPEND, CH_EQ, 28'd5);
		add(SEL_APPEND, CH_X, 28'd6);
		add(SEL_APPEND, CH_S, 28'd9);
		add(SEL_APPEND, CH_M, 28'd1);
		add(SEL_DUMP, 8'h00, 28'h0);
		add(SEL_CLIP_R, 8'h00, 28'd0);
		add(SEL_CLIP_L, 8'h00, 28'd0);
		add(SEL_TRIM, 8'h00, 28'd8);
		add(SEL_CLIP_R, 8'h00, 28'd10);
		add(SEL_CLIP_L, 8'h00, 28'd12);
		add(SEL_CLIP_R, 8'h00, 28'd1000);
		add(SEL_TRIM, 8'h00, 28'd0);
		add(SEL_APPEND, CH_BAD, 28'd3);
		add(SEL_APPEND, CH_H, 28'd3);
		add(SEL_CLIP_R, 8'h00, 28'd2);
		add(SEL_SPARE6, 8'h00, 28'h0);
		add(SEL_SPARE7, 8'hFF, LEN_MAX);
		add(SEL_DUMP, 8'h00, 28'h0);
		add_drain();

		// Fill the store with maximal matches: the aligned sum stays just below 2^34,
		// the next append is refused and a clip has no slot for its soft clip.
		add(SEL_CLEAR, 8'h00, 28'h0);
		repeat (DEPTH) add(SEL_APPEND, CH_M, LEN_MAX);
		add(SEL_APPEND, CH_I, 28'd1);
		add(SEL_DUMP, 8'h00, 28'h0);
		add(SEL_CLIP_R, 8'h00, 28'd5);
		add(SEL_CLIP_L, 8'h00, LEN_MAX);

		target = 200;
		while (cmd_q.size() < target) begin
			if ($urandom_range(0, 99) < 80) begin
				add_read();
			end else begin
				// noise: any selector, any byte, any length
				add(3'($urandom_range(0, 7)), 8'($urandom()), 28'($urandom()));
			end
			if (cmd_q.size() > target - 100 && cmd_q.size() < target - 80)
				add_drain();
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Let a burst run with no idling on either side partway through.
		while (items_sent < 150) @(posedge clk);
		no_idle = 1'b1;
		while (items_sent < 190) @(posedge clk);
		no_idle = 1'b0;

		while (cmd_q.size() > 0 || cigar_exp_q.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (cigar_exp_q.size() > 0)
			report("results still expected at end of run");

		$display("Covered %0d commands and %0d results (%0d dump entries nonzero).",
			items_sent, results_seen, dumps_seen);
		$display("Status counts ok/after/badop/long/unsup/full: %0d %0d %0d %0d %0d %0d",
			status_hits[0], status_hits[1], status_hits[2], status_hits[3],
			status_hits[4], status_hits[5]);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#100ms;
		$display("Mismatches found");
		$finish;
	end

endmodule

// File: sim.f
sv/csce_pkg.sv
sv/csce_front.sv
sv/csce_queue.sv
sv/csce_back.sv
sv/cigar_soft_clip_editor_top.sv
sv/csce_checker.sv
tb/tb_cigar_soft_clip_editor_top.sv
